### rtl/core/udprx_pkg.sv
package udprx_pkg;

	localparam int DEF_BINDING_SLOTS = 8;
	localparam logic [15:0] PROTO_UDP = 16'd17;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] CSUM_ALT_ZERO = 16'hFFFF;
	localparam logic [31:0] IP_BROADCAST = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_BIND   = 2'd0,
		KIND_UNBIND = 2'd1,
		KIND_START  = 2'd2,
		KIND_WORD   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_SHORT     = 3'd1,
		ST_EXCEED    = 3'd2,
		ST_CHECKSUM  = 3'd3,
		ST_DROPPED   = 3'd4
	} status_t;

	// one accepted input word, as held in the input register
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  slot;
		logic [31:0] bind_ip;
		logic [15:0] bind_local_port;
		logic [15:0] bind_remote_port;
		logic        bind_handler;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] data_word;
		logic        last_word;
		logic        odd_tail;
	} item_t;

	// datagram state as it stands after its last word
	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] psum;
		logic [15:0] byte_count;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] length;
		logic [15:0] checksum;
		logic [31:0] dst_ip;
	} snap_t;

	typedef struct packed {
		logic       hit;
		logic       handler;
		logic [2:0] slot;
	} match_t;

	// end-around-carry add; result never exceeds 16 bits
	function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

### rtl/core/udp_receive_check_and_demux.sv
// channel | valid        | stall        | payload
// item    | item_valid   | item_stall   | kind slot bind_* src_ip dst_ip data_word last_word odd_tail
// result  | result_valid | result_stall | status matched_slot udp_length
//
// One word per cycle while the input is not stalled; a result leaves through the input register,
// the datagram snapshot register and the result register after its last word is taken.
// The binding table is compared against all slots in parallel in the snapshot stage.
// arst_n clears the pipeline valids, the datagram state and the slot valid bits.
// A stalled result holds the snapshot stage; the input stalls only while that
// stage holds a datagram end that cannot move on.
module udp_receive_check_and_demux #(
	parameter int BINDING_SLOTS = udprx_pkg::DEF_BINDING_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  slot,
	input  logic [31:0] bind_ip,
	input  logic [15:0] bind_local_port,
	input  logic [15:0] bind_remote_port,
	input  logic        bind_handler,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [15:0] data_word,
	input  logic        last_word,
	input  logic        odd_tail,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [2:0]  matched_slot,
	output logic [15:0] udp_length
);
	import udprx_pkg::*;

	item_t   item_s1;
	logic    v_s1;
	snap_t   snap_s2;
	logic    v_s2;
	snap_t   snap_next;
	match_t  match;
	status_t status_w;
	logic [2:0] slot_w;

	logic    out_ready;
	logic    s2_go;
	logic    s2_free;
	logic    fire;
	logic    fire_last;
	logic    accept;

	status_t    status_q;
	logic [2:0] slot_q;
	logic [15:0] len_q;

	assign out_ready = !result_valid || !result_stall;
	assign s2_go = v_s2 && out_ready;
	assign s2_free = !v_s2 || out_ready;
	assign fire = v_s1 && s2_free;
	assign fire_last = fire && item_s1.kind == KIND_WORD && item_s1.last_word;
	assign item_stall = v_s1 && !s2_free;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (fire_last) begin
				v_s2 <= 1'b1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (s2_go) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind <= kind_t'(kind);
			item_s1.slot <= slot;
			item_s1.bind_ip <= bind_ip;
			item_s1.bind_local_port <= bind_local_port;
			item_s1.bind_remote_port <= bind_remote_port;
			item_s1.bind_handler <= bind_handler;
			item_s1.src_ip <= src_ip;
			item_s1.dst_ip <= dst_ip;
			item_s1.data_word <= data_word;
			item_s1.last_word <= last_word;
			item_s1.odd_tail <= odd_tail;
		end
		if (fire_last) begin
			snap_s2 <= snap_next;
		end
		if (s2_go) begin
			status_q <= status_w;
			slot_q <= slot_w;
			len_q <= snap_s2.length;
		end
	end

	udprx_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.snap   (snap_next)
	);

	// table writes happen as words leave the input register, so a datagram end
	// waiting in the snapshot stage sees only bindings made before it
	udprx_bind_table #(
		.BINDING_SLOTS (BINDING_SLOTS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.key    (snap_s2),
		.match  (match)
	);

	udprx_check u_check (
		.snap   (snap_s2),
		.match  (match),
		.status (status_w),
		.slot   (slot_w)
	);

	assign status = status_q;
	assign matched_slot = slot_q;
	assign udp_length = len_q;

	a_slot_only_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_DELIVERED |-> matched_slot == 3'd0)
		else $error("slot reported on a datagram that was not delivered");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_SHORT |-> udp_length < UDP_HDR_BYTES)
		else $error("short status with a full header length");

	a_last_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		fire_last |=> v_s2)
		else $error("datagram end lost on its way to the snapshot stage");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !s2_go |=> v_s2 && $stable(snap_s2))
		else $error("snapshot changed while waiting for the result register");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && result_valid && result_stall && v_s1 |-> item_stall)
		else $error("input taken while the pipeline is blocked");

endmodule

### rtl/core/udprx_accum.sv
module udprx_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  udprx_pkg::item_t   item,
	output udprx_pkg::snap_t   snap
);
	import udprx_pkg::*;

	logic [31:0] dst_ip_q;
	logic [15:0] psum_q;
	logic [15:0] sum_q;
	logic [15:0] cnt_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [15:0] len_q;
	logic [15:0] chk_q;

	logic [15:0] word_w;
	logic [1:0]  nbytes;
	logic [16:0] cnt_sum;
	logic [17:0] addr_sum;
	logic [16:0] addr_f1;
	logic [15:0] psum_start;

	// address part of the pseudo header, folded once per start word
	always_comb begin
		addr_sum = 18'(item.src_ip[31:16]) + 18'(item.src_ip[15:0])
			+ 18'(item.dst_ip[31:16]) + 18'(item.dst_ip[15:0]);
		addr_f1 = 17'(addr_sum[15:0]) + 17'(addr_sum[17:16]);
		psum_start = addr_f1[15:0] + 16'(addr_f1[16]);
	end

	always_comb begin
		word_w = item.data_word;
		nbytes = 2'd2;
		if (item.last_word && item.odd_tail) begin
			word_w = {item.data_word[15:8], 8'h00};
			nbytes = 2'd1;
		end
		snap.psum = psum_q;
		snap.dst_ip = dst_ip_q;
		snap.sport = (cnt_q == 16'd0) ? word_w : sport_q;
		snap.dport = (cnt_q == 16'd2) ? word_w : dport_q;
		snap.length = (cnt_q == 16'd4) ? word_w : len_q;
		snap.checksum = (cnt_q == 16'd6) ? word_w : chk_q;
		// the checksum field itself counts as zero
		snap.sum = (cnt_q == 16'd6) ? sum_q : fold_add(sum_q, word_w);
		cnt_sum = {1'b0, cnt_q} + 17'(nbytes);
		snap.byte_count = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_ip_q <= '0;
			psum_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
			len_q <= '0;
			chk_q <= '0;
		end else if (fire) begin
			case (item.kind)
				KIND_START: begin
					dst_ip_q <= item.dst_ip;
					psum_q <= psum_start;
					sum_q <= '0;
					cnt_q <= '0;
					sport_q <= '0;
					dport_q <= '0;
					len_q <= '0;
					chk_q <= '0;
				end
				KIND_WORD: begin
					if (item.last_word) begin
						sum_q <= '0;
						cnt_q <= '0;
						sport_q <= '0;
						dport_q <= '0;
						len_q <= '0;
						chk_q <= '0;
					end else begin
						sum_q <= snap.sum;
						cnt_q <= snap.byte_count;
						sport_q <= snap.sport;
						dport_q <= snap.dport;
						len_q <= snap.length;
						chk_q <= snap.checksum;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/udprx_bind_table.sv
module udprx_bind_table #(
	parameter int BINDING_SLOTS = udprx_pkg::DEF_BINDING_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  udprx_pkg::item_t  item,
	input  udprx_pkg::snap_t  key,
	output udprx_pkg::match_t match
);
	import udprx_pkg::*;

	logic [BINDING_SLOTS-1:0] valid_q;
	logic [31:0] ip_q    [BINDING_SLOTS];
	logic [15:0] lport_q [BINDING_SLOTS];
	logic [15:0] rport_q [BINDING_SLOTS];
	logic        hnd_q   [BINDING_SLOTS];
	logic [BINDING_SLOTS-1:0] sel;
	logic [BINDING_SLOTS-1:0] hit_vec;

	always_comb begin
		for (int i = 0; i < BINDING_SLOTS; i++) begin
			sel[i] = fire && (32'(item.slot) == i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < BINDING_SLOTS; i++) begin
				if (sel[i] && item.kind == KIND_BIND) begin
					valid_q[i] <= 1'b1;
				end else if (sel[i] && item.kind == KIND_UNBIND) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// a bind on a slot already in use keeps the old binding
	always_ff @(posedge clk) begin
		for (int i = 0; i < BINDING_SLOTS; i++) begin
			if (sel[i] && item.kind == KIND_BIND && !valid_q[i]) begin
				ip_q[i] <= item.bind_ip;
				lport_q[i] <= item.bind_local_port;
				rport_q[i] <= item.bind_remote_port;
				hnd_q[i] <= item.bind_handler;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < BINDING_SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && lport_q[i] == key.dport
				&& (rport_q[i] == 16'd0 || rport_q[i] == key.sport)
				&& (ip_q[i] == key.dst_ip
					|| (ip_q[i] == 32'd0 && key.dst_ip == IP_BROADCAST));
		end
	end

	// lowest slot wins
	always_comb begin
		match = '0;
		for (int i = BINDING_SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				match.hit = 1'b1;
				match.handler = hnd_q[i];
				match.slot = 3'(i);
			end
		end
	end

endmodule

### rtl/core/udprx_check.sv
module udprx_check (
	input  udprx_pkg::snap_t   snap,
	input  udprx_pkg::match_t  match,
	output udprx_pkg::status_t status,
	output logic [2:0]         slot
);
	import udprx_pkg::*;

	logic [17:0] total;
	logic [16:0] f1;
	logic [15:0] folded;
	logic [15:0] calc;
	logic        csum_bad;

	// pseudo header adds protocol and length; fold order does not matter
	always_comb begin
		total = 18'(snap.sum) + 18'(snap.psum) + 18'(snap.length) + 18'(PROTO_UDP);
		f1 = 17'(total[15:0]) + 17'(total[17:16]);
		folded = f1[15:0] + 16'(f1[16]);
		calc = ~folded;
		csum_bad = snap.checksum != 16'd0 && calc != snap.checksum
			&& !(calc == 16'd0 && snap.checksum == CSUM_ALT_ZERO);
	end

	always_comb begin
		slot = 3'd0;
		if (snap.length < UDP_HDR_BYTES) begin
			status = ST_SHORT;
		end else if (snap.length > snap.byte_count) begin
			status = ST_EXCEED;
		end else if (csum_bad) begin
			status = ST_CHECKSUM;
		end else if (match.hit && match.handler) begin
			status = ST_DELIVERED;
			slot = match.slot;
		end else begin
			status = ST_DROPPED;
		end
	end

endmodule
